// ----- design/mse_pkg.sv -----
// Package with types, constants, pattern tables and helper functions of the markup stripper.
`timescale 1ns / 1ps
package mse_pkg;

	localparam int NameDepthDef = 64;
	localparam int CmdDepth = 4;
	localparam int EntCount = 100;
	localparam int TagCount = 6;
	localparam int PatBits = 216;

	typedef logic [7:0] byte_t;

	typedef enum logic [2:0] {
		B_PRE,
		B_RD,
		B_DAT,
		B_CLOSE,
		B_LASTSP,
		B_FIN
	} back_state_t;

	// One rendering job for the back end, built by the front end from one input word.
	typedef struct packed {
		byte_t      pre0;
		byte_t      pre1;
		logic [1:0] npre;
		logic       val;
		logic [4:0] vstart;
		logic       has_close;
		byte_t      close;
		logic       last;
	} cmd_t;

	localparam byte_t ChLt   = 8'h3C;
	localparam byte_t ChGt   = 8'h3E;
	localparam byte_t ChAmp  = 8'h26;
	localparam byte_t ChSemi = 8'h3B;
	localparam byte_t ChQuot = 8'h22;
	localparam byte_t ChSp   = 8'h20;
	localparam byte_t ChTab  = 8'h09;
	localparam byte_t ChLf   = 8'h0A;
	localparam byte_t ChCr   = 8'h0D;
	localparam byte_t ChLpar = 8'h28;
	localparam byte_t ChRpar = 8'h29;

	localparam int TagStr    = 0;
	localparam int TagMor    = 1;
	localparam int TagNote   = 2;
	localparam int TagBr     = 3;
	localparam int TagP      = 4;
	localparam int TagNclose = 5;

	localparam logic [PatBits-1:0] TagPat [TagCount] = '{
		"sync type=\"Strongs\" value=\"",
		"sync type=\"morph\" value=\"",
		"note", "br", "/p", "/note"
	};
	localparam int TagLen [TagCount] = '{27, 25, 4, 2, 2, 5};

	localparam logic [47:0] EntName [EntCount] = '{
		"nbsp", "quot", "amp", "lt", "gt", "brvbar", "sect", "copy",
		"laquo", "reg", "acute", "para", "raquo",
		"Aacute", "Agrave", "Acirc", "Auml", "Atilde", "Aring",
		"aacute", "agrave", "acirc", "auml", "atilde", "aring",
		"Eacute", "Egrave", "Ecirc", "Euml", "eacute", "egrave", "ecirc", "euml",
		"Iacute", "Igrave", "Icirc", "Iuml", "iacute", "igrave", "icirc", "iuml",
		"Oacute", "Ograve", "Ocirc", "Ouml", "Otilde",
		"oacute", "ograve", "ocirc", "ouml", "otilde",
		"Uacute", "Ugrave", "Ucirc", "Uuml", "uacute", "ugrave", "ucirc", "uuml",
		"Yacute", "yacute", "yuml",
		"deg", "plusmn", "sup2", "sup3", "sup1", "pound", "cent", "frac14",
		"frac12", "frac34", "iquest", "iexcl",
		"ETH", "eth", "THORN", "thorn", "AElig", "aelig", "Oslash", "curren",
		"Ccedil", "ccedil", "szlig", "Ntilde", "ntilde", "yen", "not", "ordf",
		"uml", "shy", "macr", "micro", "middot", "cedil", "ordm", "times",
		"divide", "oslash"
	};
	localparam int EntLen [EntCount] = '{
		4, 4, 3, 2, 2, 6, 4, 4,
		5, 3, 5, 4, 5,
		6, 6, 5, 4, 6, 5,
		6, 6, 5, 4, 6, 5,
		6, 6, 5, 4, 6, 6, 5, 4,
		6, 6, 5, 4, 6, 6, 5, 4,
		6, 6, 5, 4, 6,
		6, 6, 5, 4, 6,
		6, 6, 5, 4, 6, 6, 5, 4,
		6, 6, 4,
		3, 6, 4, 4, 4, 5, 4, 6,
		6, 6, 6, 5,
		3, 3, 5, 5, 5, 5, 6, 6,
		6, 6, 5, 6, 6, 3, 3, 4,
		3, 3, 4, 5, 6, 5, 4, 5,
		6, 6
	};
	localparam byte_t EntCode [EntCount] = '{
		8'h20, 8'h22, 8'h26, 8'h3C, 8'h3E, 8'hA6, 8'hA7, 8'hA9,
		8'hAB, 8'hAE, 8'hB4, 8'hB6, 8'hBB,
		8'hC1, 8'hC0, 8'hC2, 8'hC4, 8'hC3, 8'hC5,
		8'hE1, 8'hE0, 8'hE2, 8'hE4, 8'hE3, 8'hE5,
		8'hC9, 8'hC8, 8'hCA, 8'hCB, 8'hE9, 8'hE8, 8'hEA, 8'hEB,
		8'hCD, 8'hCC, 8'hCE, 8'hCF, 8'hED, 8'hEC, 8'hEE, 8'hEF,
		8'hD3, 8'hD2, 8'hD4, 8'hD6, 8'hD5,
		8'hF3, 8'hF2, 8'hF4, 8'hF6, 8'hF5,
		8'hDA, 8'hD9, 8'hDB, 8'hDC, 8'hFA, 8'hF9, 8'hFB, 8'hFC,
		8'hDD, 8'hFD, 8'hFF,
		8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB9, 8'hA3, 8'hA2, 8'hBC,
		8'hBD, 8'hBE, 8'hBF, 8'hA1,
		8'hD0, 8'hF0, 8'hDE, 8'hFE, 8'hC6, 8'hE6, 8'hD8, 8'hA4,
		8'hC7, 8'hE7, 8'hDF, 8'hD1, 8'hF1, 8'hA5, 8'hAC, 8'hAA,
		8'hA8, 8'hAD, 8'hAF, 8'hB5, 8'hB7, 8'hB8, 8'hBA, 8'hD7,
		8'hF7, 8'hF8
	};

	// Character idx of a right-aligned string constant of length plen.
	function automatic byte_t pat_char(logic [PatBits-1:0] p, int plen, int idx);
		logic [PatBits-1:0] s;
		s = p >> ((plen - 1 - idx) * 8);
		return s[7:0];
	endfunction

	function automatic logic is_white(byte_t b);
		return (b == ChSp) || (b == ChTab) || (b == ChLf) || (b == ChCr);
	endfunction

endpackage

// ----- design/mse_in_if.sv -----
// Input channel interface carrying one text word per handshake.
`timescale 1ns / 1ps
interface mse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- design/mse_out_if.sv -----
// Output channel interface carrying one plain text word per handshake.
`timescale 1ns / 1ps
interface mse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ----- design/mse_front.sv -----
// Front end: parses input words, holds the name buffer and classifies each word into a command.
`timescale 1ns / 1ps
module mse_front import mse_pkg::*; #(
	parameter int NAME_DEPTH = NameDepthDef,
	localparam int AW = $clog2(NAME_DEPTH),
	localparam int LW = AW + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  byte_t         in_byte,
	input  logic          in_last,
	output logic          push,
	output cmd_t          push_cmd,
	input  logic          fifo_full,
	input  logic          sync_done,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output byte_t         rd_data,
	output logic [LW-1:0] name_len
);

	byte_t         name_mem [NAME_DEPTH];
	logic          in_tag_q, in_ent_q, nl_drop_q, sync_wait_q, clr_len_q;
	logic [LW-1:0] len_q;
	logic [TagCount-1:0] tag_f_q, tag_f_n;
	logic [EntCount-1:0] ent_f_q, ent_f_n;

	logic acc, nz, drop_nl, plain, start, ent_close, tag_close, store, pass, room;
	logic ent_hit, is_sync;
	byte_t ent_code;
	logic [TagCount-1:0] tag_hit;

	assign in_ready = !fifo_full && !sync_wait_q;
	assign acc = in_valid && in_ready;
	assign push = acc;
	assign name_len = len_q;

	assign nz = in_byte != 8'h00;
	assign drop_nl = nz && ((in_byte == ChLf) || (in_byte == ChCr)) && !nl_drop_q;
	assign plain = nz && !drop_nl;
	assign start = plain && ((in_byte == ChLt) || (in_byte == ChAmp));
	assign ent_close = plain && (in_byte == ChSemi) && in_ent_q;
	assign tag_close = plain && (in_byte == ChGt) && !in_ent_q;
	assign store = plain && !start && !ent_close && !tag_close && in_tag_q;
	assign pass = plain && !start && !ent_close && !tag_close && !in_tag_q;
	assign room = len_q < LW'(NAME_DEPTH);

	always_comb begin
		for (int t = 0; t < TagCount; t++) begin
			tag_hit[t] = tag_f_q[t] && (int'(len_q) >= TagLen[t]);
			tag_f_n[t] = tag_f_q[t];
			if (start) begin
				tag_f_n[t] = 1'b1;
			end else if (store && room && (int'(len_q) < TagLen[t])) begin
				if (in_byte != pat_char(TagPat[t], TagLen[t], int'(len_q))) begin
					tag_f_n[t] = 1'b0;
				end
			end
		end
		ent_hit = 1'b0;
		ent_code = 8'h00;
		for (int k = EntCount - 1; k >= 0; k--) begin
			ent_f_n[k] = ent_f_q[k];
			if (start) begin
				ent_f_n[k] = 1'b1;
			end else if (store && room && (int'(len_q) < EntLen[k])) begin
				if (in_byte != pat_char(PatBits'(EntName[k]), EntLen[k], int'(len_q))) begin
					ent_f_n[k] = 1'b0;
				end
			end
			if (ent_f_q[k] && (int'(len_q) >= EntLen[k])) begin
				ent_hit = 1'b1;
				ent_code = EntCode[k];
			end
		end
	end

	assign is_sync = tag_close && (tag_hit[TagStr] || tag_hit[TagMor]);

	always_comb begin
		push_cmd = '0;
		push_cmd.last = in_last;
		if (pass) begin
			push_cmd.npre = 2'd1;
			push_cmd.pre0 = in_byte;
		end else if (ent_close) begin
			push_cmd.npre = {1'b0, ent_hit};
			push_cmd.pre0 = ent_code;
		end else if (tag_close) begin
			priority if (tag_hit[TagStr]) begin
				push_cmd.npre = 2'd2;
				push_cmd.pre0 = ChSp;
				push_cmd.pre1 = ChLt;
				push_cmd.val = 1'b1;
				push_cmd.vstart = 5'(TagLen[TagStr]);
				push_cmd.has_close = 1'b1;
				push_cmd.close = ChGt;
			end else if (tag_hit[TagMor]) begin
				push_cmd.npre = 2'd2;
				push_cmd.pre0 = ChSp;
				push_cmd.pre1 = ChLpar;
				push_cmd.val = 1'b1;
				push_cmd.vstart = 5'(TagLen[TagMor]);
				push_cmd.has_close = 1'b1;
				push_cmd.close = ChRpar;
			end else if (tag_hit[TagNote]) begin
				push_cmd.npre = 2'd2;
				push_cmd.pre0 = ChSp;
				push_cmd.pre1 = ChLpar;
			end else if (tag_hit[TagBr] || tag_hit[TagP]) begin
				push_cmd.npre = 2'd1;
				push_cmd.pre0 = ChLf;
			end else if (tag_hit[TagNclose]) begin
				push_cmd.npre = 2'd2;
				push_cmd.pre0 = ChRpar;
				push_cmd.pre1 = ChSp;
			end else begin
				push_cmd.npre = 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && store && room) begin
			name_mem[len_q[AW-1:0]] <= in_byte;
		end
		if (rd_en) begin
			rd_data <= name_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tag_f_q <= tag_f_n;
			ent_f_q <= ent_f_n;
		end
	end

	// A sync tag closed by the final word keeps its length until its value is read out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tag_q <= 1'b0;
			in_ent_q <= 1'b0;
			nl_drop_q <= 1'b0;
			len_q <= '0;
			sync_wait_q <= 1'b0;
			clr_len_q <= 1'b0;
		end else begin
			if (sync_done) begin
				sync_wait_q <= 1'b0;
				if (clr_len_q) begin
					len_q <= '0;
					clr_len_q <= 1'b0;
				end
			end
			if (acc) begin
				if (is_sync) begin
					sync_wait_q <= 1'b1;
				end
				if (nz) begin
					nl_drop_q <= drop_nl;
				end
				if (start) begin
					in_tag_q <= 1'b1;
					in_ent_q <= (in_byte == ChAmp);
					len_q <= '0;
				end else if (ent_close) begin
					in_tag_q <= 1'b0;
					in_ent_q <= 1'b0;
				end else if (tag_close) begin
					in_tag_q <= 1'b0;
				end else if (store && room) begin
					len_q <= len_q + LW'(1);
				end
				if (in_last) begin
					in_tag_q <= 1'b0;
					in_ent_q <= 1'b0;
					nl_drop_q <= 1'b0;
					if (is_sync) begin
						clr_len_q <= 1'b1;
					end else begin
						len_q <= '0;
					end
				end
			end
		end
	end

endmodule

// ----- design/mse_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module mse_cmd_fifo import mse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PW = $clog2(CmdDepth);

	cmd_t            slot_q [CmdDepth];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;

	assign full = cnt_q == (PW+1)'(CmdDepth);
	assign empty = cnt_q == '0;
	assign head = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

// ----- design/mse_back.sv -----
// Back end: renders commands, collapses whitespace runs and drives the output register.
`timescale 1ns / 1ps
module mse_back import mse_pkg::*; #(
	parameter int NAME_DEPTH = NameDepthDef,
	localparam int AW = $clog2(NAME_DEPTH),
	localparam int LW = AW + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  logic          empty,
	output logic          pop,
	input  logic [LW-1:0] name_len,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  byte_t         rd_data,
	output logic          sync_done,
	output logic          out_valid,
	input  logic          out_ready,
	output byte_t         out_byte,
	output logic          run_last
);

	back_state_t st_q, st_n;
	logic [1:0]    k_q, k_n;
	logic [LW-1:0] idx_q, idx_n;
	logic          sp_q, sp_n;
	logic          hold_v_q, hold_v_n;
	byte_t         hold_b_q, hold_b_n;
	logic          out_v_q;
	byte_t         out_b_q;
	logic          out_l_q;

	logic  out_free, can_emit, em_req, fl_req, load, load_last, done;
	byte_t em_b, r;

	assign out_free = !out_v_q || out_ready;
	assign can_emit = !hold_v_q || out_free;
	assign out_valid = out_v_q;
	assign out_byte = out_b_q;
	assign run_last = out_l_q;
	assign rd_addr = idx_q[AW-1:0];

	always_comb begin
		st_n = st_q;
		k_n = k_q;
		idx_n = idx_q;
		sp_n = sp_q;
		em_req = 1'b0;
		em_b = ChSp;
		fl_req = 1'b0;
		pop = 1'b0;
		rd_en = 1'b0;
		sync_done = 1'b0;
		done = 1'b0;
		r = cmd.pre0;
		unique case (st_q)
			B_PRE: begin
				r = (k_q == 2'd0) ? cmd.pre0 : cmd.pre1;
			end
			B_DAT: begin
				r = rd_data;
			end
			B_CLOSE: begin
				r = cmd.close;
			end
			default: begin
				r = cmd.pre0;
			end
		endcase
		unique case (st_q)
			B_PRE, B_DAT, B_CLOSE: begin
				if (is_white(r)) begin
					sp_n = 1'b1;
					done = 1'b1;
				end else if (sp_q) begin
					em_req = 1'b1;
					em_b = ChSp;
					if (can_emit) begin
						sp_n = 1'b0;
					end
				end else begin
					em_req = 1'b1;
					em_b = r;
					done = can_emit;
				end
			end
			default: begin
				done = 1'b0;
			end
		endcase
		unique case (st_q)
			B_PRE: begin
				if (empty) begin
					em_req = 1'b0;
					sp_n = sp_q;
				end else if (k_q != cmd.npre) begin
					if (done) begin
						k_n = k_q + 2'd1;
					end
				end else begin
					em_req = 1'b0;
					sp_n = sp_q;
					k_n = 2'd0;
					if (cmd.val) begin
						idx_n = LW'(cmd.vstart);
						if (LW'(cmd.vstart) < name_len) begin
							st_n = B_RD;
						end else begin
							st_n = B_CLOSE;
							sync_done = 1'b1;
						end
					end else if (cmd.has_close) begin
						st_n = B_CLOSE;
					end else begin
						st_n = B_LASTSP;
					end
				end
			end
			B_RD: begin
				rd_en = 1'b1;
				st_n = B_DAT;
			end
			B_DAT: begin
				if (rd_data == ChQuot) begin
					em_req = 1'b0;
					sp_n = sp_q;
					st_n = B_CLOSE;
					sync_done = 1'b1;
				end else if (done) begin
					if ((idx_q + LW'(1)) < name_len) begin
						idx_n = idx_q + LW'(1);
						st_n = B_RD;
					end else begin
						st_n = B_CLOSE;
						sync_done = 1'b1;
					end
				end
			end
			B_CLOSE: begin
				if (done) begin
					st_n = B_LASTSP;
				end
			end
			B_LASTSP: begin
				if (cmd.last && sp_q) begin
					em_req = 1'b1;
					em_b = ChSp;
					if (can_emit) begin
						sp_n = 1'b0;
						st_n = B_FIN;
					end
				end else begin
					if (cmd.last) begin
						sp_n = 1'b0;
					end
					st_n = B_FIN;
				end
			end
			B_FIN: begin
				fl_req = 1'b1;
				if (!hold_v_q || out_free) begin
					pop = 1'b1;
					st_n = B_PRE;
				end
			end
			default: begin
				st_n = B_PRE;
			end
		endcase
	end

	always_comb begin
		hold_v_n = hold_v_q;
		hold_b_n = hold_b_q;
		load = 1'b0;
		load_last = 1'b0;
		if (em_req && can_emit) begin
			load = hold_v_q;
			hold_v_n = 1'b1;
			hold_b_n = em_b;
		end else if (fl_req && hold_v_q && out_free) begin
			load = 1'b1;
			load_last = 1'b1;
			hold_v_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		hold_b_q <= hold_b_n;
		if (load) begin
			out_b_q <= hold_b_q;
			out_l_q <= load_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_PRE;
			k_q <= 2'd0;
			idx_q <= '0;
			sp_q <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_n;
			k_q <= k_n;
			idx_q <= idx_n;
			sp_q <= sp_n;
			hold_v_q <= hold_v_n;
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/markup_strip_entity_decode_top.sv -----
// Top level of the markup stripper with entity decoding.
//
//  channel  | dir | payload            | handshake
//  in_ch    | in  | in_byte, in_last   | valid / ready
//  out_ch   | out | out_byte, run_last | valid / ready
//
// The front end takes one word per cycle while the command queue has room.
// The back end renders one command at a time: prefix bytes, a sync tag value, a closing byte,
// then a pending space on the last word; value bytes are read from the name buffer.
// Input stalls while a sync tag value is being read out of the name buffer.
// Reset is asynchronous; the name buffer itself is not cleared.
`timescale 1ns / 1ps
module markup_strip_entity_decode_top import mse_pkg::*; #(
	parameter int NAME_DEPTH = NameDepthDef
) (
	input logic     clk,
	input logic     arst_n,
	mse_in_if.sink    in_ch,
	mse_out_if.source out_ch
);

	localparam int AW = $clog2(NAME_DEPTH);
	localparam int LW = AW + 1;

	logic          push, full, pop, empty, sync_done, rd_en;
	cmd_t          push_cmd, head;
	logic [AW-1:0] rd_addr;
	byte_t         rd_data;
	logic [LW-1:0] name_len;

	mse_front #(.NAME_DEPTH(NAME_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_byte(in_ch.in_byte), .in_last(in_ch.in_last),
		.push(push), .push_cmd(push_cmd), .fifo_full(full),
		.sync_done(sync_done), .rd_en(rd_en), .rd_addr(rd_addr),
		.rd_data(rd_data), .name_len(name_len)
	);

	mse_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_cmd(push_cmd), .full(full),
		.pop(pop), .head(head), .empty(empty)
	);

	mse_back #(.NAME_DEPTH(NAME_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(head), .empty(empty), .pop(pop),
		.name_len(name_len), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
		.sync_done(sync_done),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_byte(out_ch.out_byte), .run_last(out_ch.run_last)
	);

	// The queue is never written while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("command queue overflow");

	// The queue is never read while empty.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("command queue underflow");

	// The name buffer is not refilled while a sync value is read from it.
	a_buf_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !in_ch.ready) else $error("input taken during value readout");

endmodule
